@@ hw/rtl/vgsi_pkg.sv @@
package vgsi_pkg;

  typedef struct packed {
    logic              glyph_start;
    logic signed [15:0] base_x;
    logic signed [15:0] base_y;
    logic signed [7:0]  vert_x;
    logic signed [7:0]  vert_y;
  } in_t;

  typedef struct packed {
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic               ink_on;
    logic               last_of_run;
  } out_t;

  typedef enum logic [0:0] {
    KIND_MOVE,
    KIND_DRAW
  } kind_e;

  localparam logic [7:0]  SCALE_RESET   = 8'd12;
  // ceil(2^17 / 3): exact quotient for dividends below 2^13
  localparam logic [15:0] RECIP3        = 16'd43691;
  localparam int          RECIP3_SHIFT  = 17;
  localparam int          MIN_STEPS     = 2;
  localparam int          LONG_SEG_LOG2 = 10;
  // 100 * r^2 <= 9 * (dx^2 + dy^2) gives the step count
  localparam logic [6:0]  STEP_SCALE    = 7'd100;

endpackage

@@ hw/rtl/vector_glyph_stroke_interpolator_core.sv @@
// A vertex that yields a point passes the front's input and product registers and then
// the 2-entry queue; the back end puts a move point straight into its output register.
// The front takes a pen lift or ignored vertex every cycle while idle, but no new vertex
// while one is in its product or queue-write state; the latter stalls while the queue is
// full. A draw vertex goes through the back end's squaring, serial root search, step divider
// and fix-up states, then gives one point per cycle while its output is taken.
// Reset: scale 12, pen state to glyph start, last point at the origin, queue empty.
module vector_glyph_stroke_interpolator_core #(
  parameter int COORD_WIDTH = 16,
  parameter int MAX_STEPS   = 30
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  vgsi_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output vgsi_pkg::out_t out_data_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [7:0]     cfg_data_i
);

  import vgsi_pkg::*;

  localparam int QW = 2 * COORD_WIDTH + 1;

  logic          q_push, q_full, q_pop, q_empty;
  logic [QW-1:0] q_wdata, q_rdata;

  assign cfg_ready_o = 1'b1;

  vgsi_front #(
    .CW (COORD_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .push_o      (q_push),
    .item_o      (q_wdata),
    .full_i      (q_full)
  );

  vgsi_fifo #(
    .WIDTH (QW),
    .DEPTH (2)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  vgsi_back #(
    .CW        (COORD_WIDTH),
    .MAX_STEPS (MAX_STEPS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .item_i      (q_rdata),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

`ifndef ASSERT_OFF
  a_queue_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && q_full))
    else $error("queue written while full");

  a_queue_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_pop && q_empty))
    else $error("queue read while empty");

  a_move_is_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.ink_on) |-> out_data_o.last_of_run)
    else $error("move point not closing its run");
`endif

endmodule

@@ hw/rtl/vgsi_fifo.sv @@
module vgsi_fifo #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wptr_q, rptr_q;
  logic [CW-1:0]    cnt_q;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        mem_q[wptr_q] <= wdata_i;
        wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

@@ hw/rtl/vgsi_front.sv @@
module vgsi_front #(
  parameter int CW = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  vgsi_pkg::in_t   in_data_i,
  input  logic            cfg_valid_i,
  input  logic [7:0]      cfg_data_i,
  output logic            push_o,
  output logic [2*CW:0]   item_o,
  input  logic            full_i
);

  import vgsi_pkg::*;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_SUM
  } fstate_e;

  localparam int SW = 18;
  localparam int EW = ((CW > SW - 1) ? CW : SW - 1) + 1;
  localparam logic signed [EW-1:0] SAT_HI = {{(EW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [EW-1:0] SAT_LO = {{(EW-CW+1){1'b1}}, {(CW-1){1'b0}}};
  localparam logic [7:0] PEN_LIFT = 8'hFF;

  fstate_e            state_q;
  logic [7:0]         scale_q;
  logic               awaiting_q, connect_q, done_q;
  kind_e              kind_q;
  logic signed [15:0] bx_q, by_q;
  logic signed [7:0]  vx_q, vy_q;
  logic [14:0]        px_q, py_q;
  logic               nx_q, ny_q;

  logic  accept, first, done_in, aw_in, cn_in, lift, zero;
  logic  aw_d, cn_d, done_d, work;
  kind_e kind;

  assign in_ready_o = (state_q == F_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign first      = in_data_i.glyph_start;
  assign done_in    = first ? 1'b0 : done_q;
  assign aw_in      = first ? 1'b1 : awaiting_q;
  assign cn_in      = first ? 1'b0 : connect_q;
  assign lift       = (in_data_i.vert_x == PEN_LIFT) && (in_data_i.vert_y == PEN_LIFT);
  assign zero       = (in_data_i.vert_x == '0) && (in_data_i.vert_y == '0);

  always_comb begin
    aw_d   = aw_in;
    cn_d   = cn_in;
    done_d = done_in;
    work   = 1'b0;
    kind   = (aw_in || !cn_in) ? KIND_MOVE : KIND_DRAW;
    if (!done_in) begin
      if (lift) begin
        cn_d = 1'b0;
      end else if (zero && !first) begin
        done_d = 1'b1;
      end else begin
        work = 1'b1;
        aw_d = 1'b0;
        cn_d = 1'b1;
      end
    end
  end

  // |v| * scale
  logic [7:0]  ax, ay;
  logic [15:0] prodx, prody;
  assign ax    = vx_q[7] ? (~vx_q + 8'd1) : vx_q;
  assign ay    = vy_q[7] ? (~vy_q + 8'd1) : vy_q;
  assign prodx = ax * scale_q;
  assign prody = ay * scale_q;

  // product / 12 as (product / 4) / 3, then offset and saturate
  logic [28:0]          rx, ry;
  logic [11:0]          qx, qy;
  logic signed [SW-1:0] offx, offy, sumx, sumy;
  logic signed [EW-1:0] extx, exty;
  logic [CW-1:0]        satx, saty;

  assign rx   = px_q[14:2] * RECIP3;
  assign ry   = py_q[14:2] * RECIP3;
  assign qx   = rx[28:RECIP3_SHIFT];
  assign qy   = ry[28:RECIP3_SHIFT];
  assign offx = nx_q ? -$signed({6'b0, qx}) : $signed({6'b0, qx});
  assign offy = ny_q ? -$signed({6'b0, qy}) : $signed({6'b0, qy});
  assign sumx = $signed({{2{bx_q[15]}}, bx_q}) + offx;
  assign sumy = $signed({{2{by_q[15]}}, by_q}) + offy;
  assign extx = EW'(sumx);
  assign exty = EW'(sumy);

  always_comb begin
    if (extx > SAT_HI) begin
      satx = SAT_HI[CW-1:0];
    end else if (extx < SAT_LO) begin
      satx = SAT_LO[CW-1:0];
    end else begin
      satx = extx[CW-1:0];
    end
    if (exty > SAT_HI) begin
      saty = SAT_HI[CW-1:0];
    end else if (exty < SAT_LO) begin
      saty = SAT_LO[CW-1:0];
    end else begin
      saty = exty[CW-1:0];
    end
  end

  assign push_o = (state_q == F_SUM) && !full_i;
  assign item_o = {kind_q, satx, saty};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= F_IDLE;
      scale_q    <= SCALE_RESET;
      awaiting_q <= 1'b1;
      connect_q  <= 1'b0;
      done_q     <= 1'b0;
      kind_q     <= KIND_MOVE;
      bx_q       <= '0;
      by_q       <= '0;
      vx_q       <= '0;
      vy_q       <= '0;
      px_q       <= '0;
      py_q       <= '0;
      nx_q       <= 1'b0;
      ny_q       <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        scale_q <= cfg_data_i;
      end
      case (state_q)
        F_IDLE: begin
          if (accept) begin
            awaiting_q <= aw_d;
            connect_q  <= cn_d;
            done_q     <= done_d;
            kind_q     <= kind;
            bx_q       <= in_data_i.base_x;
            by_q       <= in_data_i.base_y;
            vx_q       <= in_data_i.vert_x;
            vy_q       <= in_data_i.vert_y;
            if (work) begin
              state_q <= F_MUL;
            end
          end
        end
        F_MUL: begin
          px_q    <= prodx[14:0];
          py_q    <= prody[14:0];
          nx_q    <= vx_q[7];
          ny_q    <= vy_q[7];
          state_q <= F_SUM;
        end
        F_SUM: begin
          if (!full_i) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/vgsi_back.sv @@
module vgsi_back #(
  parameter int CW        = 16,
  parameter int MAX_STEPS = 30
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  logic [2*CW:0]  item_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output vgsi_pkg::out_t out_data_o
);

  import vgsi_pkg::*;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SQ,
    B_SRCH,
    B_DIV,
    B_FIX,
    B_PT
  } bstate_e;

  localparam int DW   = CW + 1;
  localparam int NB   = $clog2(MAX_STEPS + 1);
  localparam int CNTW = $clog2(DW + 1);
  localparam int OW   = (DW > 16) ? DW : 16;
  localparam int PW   = 2 * NB + 7;
  localparam int MW   = (PW > 25) ? PW : 25;

  function automatic logic [15:0] to16(input logic signed [DW-1:0] v);
    logic signed [OW-1:0] e;
    e = OW'(v);
    return e[15:0];
  endfunction

  bstate_e              state_q;
  logic signed [CW-1:0] prevx_q, prevy_q, sx_q, sy_q;
  logic signed [DW-1:0] dx_q, dy_q;
  logic                 big_q;
  logic [24:0]          s9_q;
  logic [NB-1:0]        res_q, mask_q, n_q, j_q;
  logic [DW-1:0]        dvx_q, dvy_q;
  logic [NB-1:0]        rmx_q, rmy_q;
  logic [CNTW-1:0]      cnt_q;
  logic signed [DW-1:0] qdx_q, qdy_q, accx_q, accy_q;
  logic [NB-1:0]        rdx_q, rdy_q, rax_q, ray_q;
  logic                 out_valid_q;
  out_t                 out_q;

  kind_e                ikind;
  logic signed [CW-1:0] isx, isy;
  logic                 slot_free;
  logic                 emit;

  assign ikind     = kind_e'(item_i[2*CW]);
  assign isx       = item_i[2*CW-1:CW];
  assign isy       = item_i[CW-1:0];
  assign slot_free = !out_valid_q || out_ready_i;
  assign pop_o     = (state_q == B_IDLE) && !empty_i && ((ikind == KIND_DRAW) || slot_free);
  assign emit      = ((state_q == B_IDLE) && pop_o && (ikind == KIND_MOVE)) ||
                     ((state_q == B_PT) && slot_free);

  // segment length
  logic [DW-1:0] adx, ady;
  logic [19:0]   ax2, ay2;
  logic [20:0]   ss;
  logic          big;
  assign adx = dx_q[DW-1] ? DW'(-dx_q) : DW'(dx_q);
  assign ady = dy_q[DW-1] ? DW'(-dy_q) : DW'(dy_q);
  assign big = (adx[DW-1:LONG_SEG_LOG2] != '0) || (ady[DW-1:LONG_SEG_LOG2] != '0);
  assign ax2 = adx[9:0] * adx[9:0];
  assign ay2 = ady[9:0] * ady[9:0];
  assign ss  = ax2 + ay2;

  // step count: one bit of the root per cycle
  logic [NB-1:0]   cand, nres, nfin;
  logic [2*NB-1:0] csq;
  logic [PW-1:0]   c100;
  logic            cok;
  assign cand = res_q | mask_q;
  assign csq  = cand * cand;
  assign c100 = csq * STEP_SCALE;
  assign cok  = (cand <= NB'(MAX_STEPS)) && (MW'(c100) <= MW'(s9_q));
  assign nres = cok ? cand : res_q;
  assign nfin = big_q ? NB'(MAX_STEPS) : ((nres < NB'(MIN_STEPS)) ? NB'(MIN_STEPS) : nres);

  // restoring divide of |d| by n
  logic [NB:0] shx, shy;
  logic        gex, gey;
  assign shx = {rmx_q, dvx_q[DW-1]};
  assign shy = {rmy_q, dvy_q[DW-1]};
  assign gex = shx >= {1'b0, n_q};
  assign gey = shy >= {1'b0, n_q};

  // floor quotient and remainder of d / n
  logic                 negx, negy;
  logic signed [DW-1:0] fqx, fqy;
  logic [NB-1:0]        frx, fry;
  always_comb begin
    negx = dx_q[DW-1];
    negy = dy_q[DW-1];
    if (!negx) begin
      fqx = dvx_q;
      frx = rmx_q;
    end else if (rmx_q != '0) begin
      fqx = ~dvx_q;
      frx = n_q - rmx_q;
    end else begin
      fqx = ~dvx_q + DW'(1);
      frx = '0;
    end
    if (!negy) begin
      fqy = dvy_q;
      fry = rmy_q;
    end else if (rmy_q != '0) begin
      fqy = ~dvy_q;
      fry = n_q - rmy_q;
    end else begin
      fqy = ~dvy_q + DW'(1);
      fry = '0;
    end
  end

  // running quotient/remainder of (prev*n + j*d) / n
  logic signed [DW-1:0] ptx, pty;
  logic [NB:0]          rsx, rsy;
  logic                 cyx, cyy;
  assign ptx = (accx_q[DW-1] && rax_q != '0) ? accx_q + DW'(1) : accx_q;
  assign pty = (accy_q[DW-1] && ray_q != '0) ? accy_q + DW'(1) : accy_q;
  assign rsx = {1'b0, rax_q} + {1'b0, rdx_q};
  assign rsy = {1'b0, ray_q} + {1'b0, rdy_q};
  assign cyx = rsx >= {1'b0, n_q};
  assign cyy = rsy >= {1'b0, n_q};

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      prevx_q     <= '0;
      prevy_q     <= '0;
      sx_q        <= '0;
      sy_q        <= '0;
      dx_q        <= '0;
      dy_q        <= '0;
      big_q       <= 1'b0;
      s9_q        <= '0;
      res_q       <= '0;
      mask_q      <= '0;
      n_q         <= '0;
      j_q         <= '0;
      dvx_q       <= '0;
      dvy_q       <= '0;
      rmx_q       <= '0;
      rmy_q       <= '0;
      cnt_q       <= '0;
      qdx_q       <= '0;
      qdy_q       <= '0;
      accx_q      <= '0;
      accy_q      <= '0;
      rdx_q       <= '0;
      rdy_q       <= '0;
      rax_q       <= '0;
      ray_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        B_IDLE: begin
          if (pop_o) begin
            if (ikind == KIND_MOVE) begin
              out_q.point_x     <= to16(DW'(isx));
              out_q.point_y     <= to16(DW'(isy));
              out_q.ink_on      <= 1'b0;
              out_q.last_of_run <= 1'b1;
              prevx_q           <= isx;
              prevy_q           <= isy;
            end else begin
              sx_q    <= isx;
              sy_q    <= isy;
              dx_q    <= DW'(isx) - DW'(prevx_q);
              dy_q    <= DW'(isy) - DW'(prevy_q);
              state_q <= B_SQ;
            end
          end
        end
        B_SQ: begin
          big_q   <= big;
          s9_q    <= {1'b0, ss, 3'b000} + {4'b0000, ss};
          res_q   <= '0;
          mask_q  <= {1'b1, {(NB-1){1'b0}}};
          state_q <= B_SRCH;
        end
        B_SRCH: begin
          res_q  <= nres;
          mask_q <= mask_q >> 1;
          if (mask_q[0]) begin
            n_q     <= nfin;
            dvx_q   <= adx;
            dvy_q   <= ady;
            rmx_q   <= '0;
            rmy_q   <= '0;
            cnt_q   <= '0;
            state_q <= B_DIV;
          end
        end
        B_DIV: begin
          rmx_q <= gex ? NB'(shx - {1'b0, n_q}) : shx[NB-1:0];
          rmy_q <= gey ? NB'(shy - {1'b0, n_q}) : shy[NB-1:0];
          dvx_q <= {dvx_q[DW-2:0], gex};
          dvy_q <= {dvy_q[DW-2:0], gey};
          cnt_q <= cnt_q + CNTW'(1);
          if (cnt_q == CNTW'(DW - 1)) begin
            state_q <= B_FIX;
          end
        end
        B_FIX: begin
          qdx_q   <= fqx;
          qdy_q   <= fqy;
          rdx_q   <= frx;
          rdy_q   <= fry;
          accx_q  <= DW'(prevx_q);
          accy_q  <= DW'(prevy_q);
          rax_q   <= '0;
          ray_q   <= '0;
          j_q     <= '0;
          state_q <= B_PT;
        end
        B_PT: begin
          if (slot_free) begin
            out_q.point_x     <= to16(ptx);
            out_q.point_y     <= to16(pty);
            out_q.ink_on      <= 1'b1;
            out_q.last_of_run <= (j_q == n_q);
            rax_q  <= cyx ? NB'(rsx - {1'b0, n_q}) : rsx[NB-1:0];
            ray_q  <= cyy ? NB'(rsy - {1'b0, n_q}) : rsy[NB-1:0];
            accx_q <= accx_q + qdx_q + (cyx ? DW'(1) : DW'(0));
            accy_q <= accy_q + qdy_q + (cyy ? DW'(1) : DW'(0));
            j_q    <= j_q + NB'(1);
            if (j_q == n_q) begin
              prevx_q <= sx_q;
              prevy_q <= sy_q;
              state_q <= B_IDLE;
            end
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

endmodule

@@ bench/tb_vector_glyph_stroke_interpolator_core.sv @@
module tb_vector_glyph_stroke_interpolator_core;
  timeunit 1ns;
  timeprecision 1ps;

  import vgsi_pkg::*;

  localparam int  CYCLE_HALF    = 10;
  localparam int  RESET_CYCLES  = 11;
  localparam int  SETTLE_CYCLES = 200;
  localparam int  STALL_LIMIT   = 4000;
  localparam int  ITEMS_PER_RUN = 45;
  localparam int  N_RUNS        = 8;
  localparam int  STEPS_MAX     = 30;
  localparam int  SCALE_DIV     = 12;
  localparam int  LONG_SEG      = 1024;
  localparam int  COORD_MAX     = 32767;
  localparam int  COORD_MIN     = -32768;
  localparam int  PEN_LIFT      = -1;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_t        in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_t       out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = SCALE_RESET;

  vector_glyph_stroke_interpolator_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #CYCLE_HALF clk_i = 1'b1;
    #CYCLE_HALF clk_i = 1'b0;
  end

  // shadow of the block's state
  logic [7:0] scale_shadow = SCALE_RESET;
  longint     last_x = 0;
  longint     last_y = 0;
  bit         wait_first = 1'b1;
  bit         join_next = 1'b0;
  bit         glyph_over = 1'b0;

  in_t  vertex_q[$];
  out_t point_q[$];
  bit   vertex_taken = 1'b0;
  bit   hold_off = 1'b0;
  int   in_idle_pct = 0;
  int   out_stall_pct = 0;
  int   fails = 0;
  int   vertices_sent = 0;
  int   points_checked = 0;
  int   quiet_cycles = 0;

  function automatic longint clamp_coord(longint v);
    if (v > COORD_MAX) return COORD_MAX;
    if (v < COORD_MIN) return COORD_MIN;
    return v;
  endfunction

  function automatic longint seg_steps(longint dx, longint dy);
    longint n;
    longint q;
    longint r;
    if (dx >= LONG_SEG || -dx >= LONG_SEG || dy >= LONG_SEG || -dy >= LONG_SEG) begin
      n = STEPS_MAX;
    end else begin
      q = (9 * (dx * dx + dy * dy)) / 100;
      r = 0;
      while (r < 64 && (r + 1) * (r + 1) <= q) r++;
      n = r;
    end
    if (n < MIN_STEPS) n = MIN_STEPS;
    if (n > STEPS_MAX) n = STEPS_MAX;
    return n;
  endfunction

  function automatic out_t mk_point(longint x, longint y, kind_e kind, bit last);
    out_t p;
    p.point_x     = x[15:0];
    p.point_y     = y[15:0];
    p.ink_on      = (kind == KIND_DRAW);
    p.last_of_run = last;
    return p;
  endfunction

  task automatic trace_vertex(in_t v);
    longint bx;
    longint by;
    longint vx;
    longint vy;
    longint sc;
    longint sx;
    longint sy;
    longint dx;
    longint dy;
    longint n;
    bx = v.base_x;
    by = v.base_y;
    vx = v.vert_x;
    vy = v.vert_y;
    sc = scale_shadow;
    if (v.glyph_start) begin
      glyph_over = 1'b0;
      wait_first = 1'b1;
      join_next  = 1'b0;
    end
    if (glyph_over) return;
    if (vx == PEN_LIFT && vy == PEN_LIFT) begin
      join_next = 1'b0;
      return;
    end
    if (vx == 0 && vy == 0 && !v.glyph_start) begin
      glyph_over = 1'b1;
      return;
    end
    sx = clamp_coord(bx + (vx * sc) / SCALE_DIV);
    sy = clamp_coord(by + (vy * sc) / SCALE_DIV);
    if (wait_first || !join_next) begin
      point_q.push_back(mk_point(sx, sy, KIND_MOVE, 1'b1));
      wait_first = 1'b0;
      join_next  = 1'b1;
    end else begin
      dx = sx - last_x;
      dy = sy - last_y;
      n  = seg_steps(dx, dy);
      for (longint j = 0; j <= n; j++) begin
        point_q.push_back(mk_point((last_x * n + j * dx) / n, (last_y * n + j * dy) / n,
                                   KIND_DRAW, j == n));
      end
    end
    last_x = sx;
    last_y = sy;
  endtask

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  // driver
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || vertex_taken)) begin
      vertex_taken = 1'b0;
      if (vertex_q.size() != 0 && !hold_off && $urandom_range(99) >= in_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= vertex_q[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  // monitor
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        trace_vertex(in_data);
        void'(vertex_q.pop_front());
        vertex_taken = 1'b1;
        vertices_sent++;
      end
      if (out_valid && out_ready) begin
        if (point_q.size() == 0) begin
          $error("point (%0d,%0d) with no expected transaction",
                 out_data.point_x, out_data.point_y);
          fails++;
        end else begin
          want = point_q.pop_front();
          check_field("point_x", want.point_x, out_data.point_x);
          check_field("point_y", want.point_y, out_data.point_y);
          check_field("ink_on", want.ink_on, out_data.ink_on);
          check_field("last_of_run", want.last_of_run, out_data.last_of_run);
          points_checked++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: %0d points still expected", point_q.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic in_t mk_vertex(bit gs, int bx, int by, int vx, int vy);
    in_t v;
    v.glyph_start = gs;
    v.base_x      = bx[15:0];
    v.base_y      = by[15:0];
    v.vert_x      = vx[7:0];
    v.vert_y      = vy[7:0];
    return v;
  endfunction

  function automatic int pick_base();
    case ($urandom_range(9))
      0:       return COORD_MAX;
      1:       return COORD_MIN;
      2:       return int'($signed(16'($urandom)));
      default: return int'($urandom_range(4000)) - 2000;
    endcase
  endfunction

  task automatic wait_drained();
    do @(posedge clk_i);
    while (vertex_q.size() != 0 || in_valid || point_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_scale(logic [7:0] value);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i);
    while (!cfg_ready);
    scale_shadow = value;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_idle(idle_mode_e mode);
    case (mode)
      IDLE_NONE:     begin in_idle_pct = 0;  out_stall_pct = 0;  end
      IDLE_SENDER:   begin in_idle_pct = 54; out_stall_pct = 0;  end
      IDLE_RECEIVER: begin in_idle_pct = 0;  out_stall_pct = 54; end
      default:       begin in_idle_pct = 26; out_stall_pct = 26; end
    endcase
  endtask

  // one glyph: start slot, strokes with the odd pen lift, usually a terminator
  task automatic queue_glyph();
    int bx;
    int by;
    int len;
    int vx;
    int vy;
    bx  = pick_base();
    by  = pick_base();
    len = $urandom_range(6, 1);
    vertex_q.push_back(mk_vertex(1'b1, bx, by, $urandom_range(127), $urandom_range(127)));
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(19) == 0) begin
        bx = pick_base();
        by = pick_base();
      end
      if ($urandom_range(9) == 0) begin
        vertex_q.push_back(mk_vertex(1'b0, bx, by, PEN_LIFT, PEN_LIFT));
      end else begin
        vx = $urandom_range(127);
        vy = $urandom_range(127);
        if (vx == 0 && vy == 0) vx = 1;
        vertex_q.push_back(mk_vertex(1'b0, bx, by, vx, vy));
      end
    end
    if ($urandom_range(99) < 85) begin
      vertex_q.push_back(mk_vertex(1'b0, bx, by, 0, 0));
      repeat ($urandom_range(2)) begin
        vertex_q.push_back(mk_vertex(1'b0, bx, by, $urandom_range(127), $urandom_range(127)));
      end
    end
  endtask

  task automatic queue_noise();
    vertex_q.push_back(mk_vertex($urandom_range(1), int'($signed(16'($urandom))),
                                 int'($signed(16'($urandom))),
                                 int'($urandom_range(128)) - 1,
                                 int'($urandom_range(128)) - 1));
  endtask

  logic [7:0] run_scale[N_RUNS];
  int         queued;

  initial begin
    run_scale = '{8'd255, 8'd1, 8'd0, 8'($urandom), 8'd12, 8'($urandom), 8'd200,
                  8'($urandom)};
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed, reset scale
    set_idle(IDLE_NONE);
    vertex_q.push_back(mk_vertex(1'b0, 100, 200, 10, 20));
    vertex_q.push_back(mk_vertex(1'b0, 100, 200, 127, 127));
    vertex_q.push_back(mk_vertex(1'b0, 100, 200, PEN_LIFT, PEN_LIFT));
    vertex_q.push_back(mk_vertex(1'b0, 100, 200, 5, 5));
    vertex_q.push_back(mk_vertex(1'b0, 100, 200, 0, 0));
    vertex_q.push_back(mk_vertex(1'b0, 100, 200, 30, 30));
    vertex_q.push_back(mk_vertex(1'b1, 0, 0, 0, 0));
    vertex_q.push_back(mk_vertex(1'b0, 0, 0, 1, 0));
    vertex_q.push_back(mk_vertex(1'b0, 0, 0, 127, 0));
    vertex_q.push_back(mk_vertex(1'b0, 0, 0, PEN_LIFT, PEN_LIFT));
    vertex_q.push_back(mk_vertex(1'b0, 0, 0, PEN_LIFT, PEN_LIFT));
    vertex_q.push_back(mk_vertex(1'b0, 0, 0, 64, 64));
    vertex_q.push_back(mk_vertex(1'b1, COORD_MAX, COORD_MAX, 127, 127));
    vertex_q.push_back(mk_vertex(1'b0, COORD_MIN, COORD_MIN, 0, 1));
    vertex_q.push_back(mk_vertex(1'b0, COORD_MIN, COORD_MIN, 127, 0));
    vertex_q.push_back(mk_vertex(1'b0, 0, -1, 0, 0));
    vertex_q.push_back(mk_vertex(1'b1, -100, -100, PEN_LIFT, PEN_LIFT));
    vertex_q.push_back(mk_vertex(1'b0, -100, -100, 2, 3));
    vertex_q.push_back(mk_vertex(1'b0, -100, -100, 3, 3));
    vertex_q.push_back(mk_vertex(1'b1, 1234, -1234, 50, 60));
    vertex_q.push_back(mk_vertex(1'b0, 1234, -1234, 51, 60));
    vertex_q.push_back(mk_vertex(1'b0, 1234, -1234, 0, 0));
    wait_drained();

    for (int run = 0; run < N_RUNS; run++) begin
      write_scale(run_scale[run]);
      set_idle(idle_mode_e'((run + 1) % 4));
      queued = 0;
      while (queued < ITEMS_PER_RUN) begin
        if ($urandom_range(99) < 15) begin
          queue_noise();
          queued++;
        end else begin
          queued -= vertex_q.size();
          queue_glyph();
          queued += vertex_q.size();
        end
      end
      if (run == 2) begin
        while (vertex_q.size() > ITEMS_PER_RUN / 2) @(posedge clk_i);
        hold_off = 1'b1;
        do @(posedge clk_i);
        while (in_valid || point_q.size() != 0);
        hold_off = 1'b0;
      end
      wait_drained();
    end

    $display("%0d vertices sent, %0d points checked across %0d scale settings",
             vertices_sent, points_checked, N_RUNS + 1);
    $display("idle patterns: none, sender, receiver and both, with one drain-and-hold pause");
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/vgsi_pkg.sv
hw/rtl/vgsi_fifo.sv
hw/rtl/vgsi_front.sv
hw/rtl/vgsi_back.sv
hw/rtl/vector_glyph_stroke_interpolator_core.sv
bench/tb_vector_glyph_stroke_interpolator_core.sv
